FILE: rtl/core/shm_pkg.sv
// Package with constants and types shared by the shingle min-hash block.
`timescale 1ns / 1ps
package shm_pkg;

   localparam int MAX_SHINGLE = 8;
   localparam int WIN_IDX_W   = $clog2(MAX_SHINGLE);
   localparam int CNT_W       = $clog2(MAX_SHINGLE + 1);

   localparam logic [7:0] LINE_FEED    = 8'h0A;
   localparam logic [7:0] CARRIAGE_RET = 8'h0D;

   localparam logic [3:0] SHINGLE_RESET = 4'd3;

   // Multiplier constants of the short hash paths
   localparam logic [63:0] P64_2    = 64'hC2B2_AE3D_27D4_EB4F;
   localparam logic [63:0] P64_3    = 64'h1656_67B1_9E37_79F9;
   localparam logic [63:0] RRMX_MUL = 64'h9FB2_1C65_1E98_DF25;

   // Secret words folded together for each length class
   localparam logic [63:0] KEY_EMPTY = 64'h8726_F910_5DC2_1DDC;
   localparam logic [63:0] KEY_1TO3  = 64'h0000_0000_8727_5A9B;
   localparam logic [63:0] KEY_4TO8  = 64'hC73A_B174_C5EC_D5A2;

   localparam logic [63:0] HASH_INIT = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MAIN,
      ST_PRE,
      ST_MUL1,
      ST_MID,
      ST_MUL2,
      ST_POST,
      ST_FINISH,
      ST_EMIT
   } state_type;

   // What follows a finished hash
   typedef enum logic [1:0] {
      CONT_CR,
      CONT_BYTE,
      CONT_FINISH
   } cont_type;

endpackage

FILE: rtl/core/shingle_minhash.sv
// Min-hash of byte shingles over one text line, with a shared 32x32 multiplier.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_ready | req_data_byte, req_end_of_buffer
//   rsp     | out       | rsp_valid/rsp_ready | rsp_cluster_hash, rsp_short_string
//   csr     | in        | csr_valid/csr_ready | csr_shingle_size
//
// One short hash is made of two 64-bit multiplies, each built from three partial products
// of the single 32x32 multiplier, and a byte that closes a window makes one such hash.
// A held carriage return that enters the string adds one more hash, and a short string
// at the end adds one more. Ending a string passes through the finish and emit states,
// and the emit state loads the result into the output register.
// Reset is synchronous and clears the state, window, count, minimum, flags and output valid.
// The result sits in an output register; a new result waits until the previous one is taken.
`timescale 1ns / 1ps
module shingle_minhash (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_buffer,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_cluster_hash,
   output logic        rsp_short_string,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_shingle_size
);

   localparam int MS = shm_pkg::MAX_SHINGLE;
   localparam int IW = shm_pkg::WIN_IDX_W;
   localparam int CW = shm_pkg::CNT_W;

   shm_pkg::state_type state_ff, state_in;
   shm_pkg::cont_type  cont_ff, cont_in;

   logic [MS-1:0][7:0] win_ff, win_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [63:0]        min_ff, min_in;
   logic               pending_ff, pending_in;
   logic               skipping_ff, skipping_in;
   logic [3:0]         shingle_ff, shingle_in;
   logic [7:0]         byte_ff, byte_in;
   logic               last_ff, last_in;
   logic [3:0]         n_ff, n_in;
   logic [63:0]        acc_ff, acc_in;
   logic [63:0]        prod_ff, prod_in;
   logic [63:0]        sum_ff, sum_in;
   logic [1:0]         step_ff, step_in;
   logic [63:0]        res_ff, res_in;
   logic               res_short_ff, res_short_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [63:0]        rsp_hash_ff, rsp_hash_in;
   logic               rsp_short_ff, rsp_short_in;

   logic [CW-1:0] wsize;
   logic [CW-1:0] cnt_inc;
   logic          is_lf, is_cr;
   logic          path_a;
   logic [63:0]   seed;
   logic [63:0]   hash_out;
   logic [63:0]   mul_k;
   logic [31:0]   mul_a, mul_b;
   logic [63:0]   mul_p;

   // Clamp the window size to 1..MAX_SHINGLE
   always_comb begin
      if (shingle_ff == 4'd0) begin
         wsize = CW'(1);
      end else if (32'(shingle_ff) > MS) begin
         wsize = CW'(MS);
      end else begin
         wsize = CW'(shingle_ff);
      end
   end

   assign cnt_inc = (32'(count_ff) < MS) ? count_ff + CW'(1) : count_ff;
   assign is_lf   = (byte_ff == shm_pkg::LINE_FEED);
   assign is_cr   = (byte_ff == shm_pkg::CARRIAGE_RET);
   assign path_a  = (n_ff < 4'd4);

   // Starting word of the hash from the newest n bytes of the window
   always_comb begin
      logic [IW-1:0] base;
      logic [IW-1:0] mid_idx;
      logic [31:0]   comb_w;
      logic [31:0]   head32;
      logic [31:0]   tail32;
      base    = IW'(MS - 32'(n_ff));
      mid_idx = base + IW'(n_ff >> 1);
      comb_w  = {win_ff[mid_idx], win_ff[base], 4'd0, n_ff, win_ff[MS-1]};
      head32  = {win_ff[base + IW'(3)], win_ff[base + IW'(2)],
                 win_ff[base + IW'(1)], win_ff[base]};
      tail32  = {win_ff[MS-1], win_ff[MS-2], win_ff[MS-3], win_ff[MS-4]};
      if (n_ff == 4'd0) begin
         seed = shm_pkg::KEY_EMPTY;
      end else if (path_a) begin
         seed = {32'd0, comb_w} ^ shm_pkg::KEY_1TO3;
      end else begin
         seed = ({32'd0, tail32} + {head32, 32'd0}) ^ shm_pkg::KEY_4TO8;
      end
   end

   assign hash_out = path_a ? (sum_ff ^ (sum_ff >> 32)) : (sum_ff ^ (sum_ff >> 28));

   // Shared multiplier: low 64 bits of acc * k from three partial products
   always_comb begin
      if (state_ff == shm_pkg::ST_MUL1) begin
         mul_k = path_a ? shm_pkg::P64_2 : shm_pkg::RRMX_MUL;
      end else begin
         mul_k = path_a ? shm_pkg::P64_3 : shm_pkg::RRMX_MUL;
      end
      case (step_ff)
         2'd0: begin
            mul_a = acc_ff[31:0];
            mul_b = mul_k[31:0];
         end
         2'd1: begin
            mul_a = acc_ff[63:32];
            mul_b = mul_k[31:0];
         end
         default: begin
            mul_a = acc_ff[31:0];
            mul_b = mul_k[63:32];
         end
      endcase
   end

   assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         shm_pkg::ST_IDLE: begin
            if (req_valid) state_in = shm_pkg::ST_DECODE;
         end
         shm_pkg::ST_DECODE: begin
            if (skipping_ff) begin
               state_in = shm_pkg::ST_IDLE;
            end else if (pending_ff && !is_lf && cnt_inc >= wsize) begin
               state_in = shm_pkg::ST_PRE;
            end else begin
               state_in = shm_pkg::ST_MAIN;
            end
         end
         shm_pkg::ST_MAIN: begin
            if (is_lf) begin
               state_in = shm_pkg::ST_FINISH;
            end else if (is_cr && !last_ff) begin
               state_in = shm_pkg::ST_IDLE;
            end else if (cnt_inc >= wsize) begin
               state_in = shm_pkg::ST_PRE;
            end else begin
               state_in = last_ff ? shm_pkg::ST_FINISH : shm_pkg::ST_IDLE;
            end
         end
         shm_pkg::ST_PRE: state_in = shm_pkg::ST_MUL1;
         shm_pkg::ST_MUL1: begin
            if (step_ff == 2'd3) state_in = shm_pkg::ST_MID;
         end
         shm_pkg::ST_MID: state_in = shm_pkg::ST_MUL2;
         shm_pkg::ST_MUL2: begin
            if (step_ff == 2'd3) state_in = shm_pkg::ST_POST;
         end
         shm_pkg::ST_POST: begin
            case (cont_ff)
               shm_pkg::CONT_CR:   state_in = shm_pkg::ST_MAIN;
               shm_pkg::CONT_BYTE: state_in = last_ff ? shm_pkg::ST_FINISH : shm_pkg::ST_IDLE;
               default:            state_in = shm_pkg::ST_EMIT;
            endcase
         end
         shm_pkg::ST_FINISH: begin
            state_in = (count_ff < wsize) ? shm_pkg::ST_PRE : shm_pkg::ST_EMIT;
         end
         shm_pkg::ST_EMIT: begin
            if (!rsp_valid_ff) state_in = shm_pkg::ST_IDLE;
         end
         default: state_in = shm_pkg::ST_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      win_in       = win_ff;
      count_in     = count_ff;
      min_in       = min_ff;
      pending_in   = pending_ff;
      skipping_in  = skipping_ff;
      shingle_in   = csr_valid ? csr_shingle_size : shingle_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      n_in         = n_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      sum_in       = sum_ff;
      step_in      = 2'd0;
      cont_in      = cont_ff;
      res_in       = res_ff;
      res_short_in = res_short_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_hash_in  = rsp_hash_ff;
      rsp_short_in = rsp_short_ff;
      case (state_ff)
         shm_pkg::ST_IDLE: begin
            if (req_valid) begin
               byte_in = req_data_byte;
               last_in = req_end_of_buffer;
            end
         end
         shm_pkg::ST_DECODE: begin
            if (skipping_ff) begin
               skipping_in = !last_ff;
            end else if (pending_ff) begin
               pending_in = 1'b0;
               if (!is_lf) begin
                  // the held carriage return enters the string
                  win_in   = {shm_pkg::CARRIAGE_RET, win_ff[MS-1:1]};
                  count_in = cnt_inc;
                  n_in     = 4'(wsize);
                  cont_in  = shm_pkg::CONT_CR;
               end
            end
         end
         shm_pkg::ST_MAIN: begin
            if (is_lf) begin
               skipping_in = !last_ff;
            end else if (is_cr && !last_ff) begin
               pending_in = 1'b1;
            end else begin
               win_in   = {byte_ff, win_ff[MS-1:1]};
               count_in = cnt_inc;
               n_in     = 4'(wsize);
               cont_in  = shm_pkg::CONT_BYTE;
            end
         end
         shm_pkg::ST_PRE: begin
            acc_in = path_a ? (seed ^ (seed >> 33))
                            : (seed ^ {seed[14:0], seed[63:15]} ^ {seed[39:0], seed[63:40]});
         end
         shm_pkg::ST_MUL1, shm_pkg::ST_MUL2: begin
            step_in = step_ff + 2'd1;
            prod_in = mul_p;
            case (step_ff)
               2'd0:    sum_in = sum_ff;
               2'd1:    sum_in = prod_ff;
               default: sum_in = sum_ff + {prod_ff[31:0], 32'd0};
            endcase
         end
         shm_pkg::ST_MID: begin
            acc_in = path_a ? (sum_ff ^ (sum_ff >> 29))
                            : (sum_ff ^ ((sum_ff >> 35) + {60'd0, n_ff}));
         end
         shm_pkg::ST_POST: begin
            if (cont_ff == shm_pkg::CONT_FINISH) begin
               res_in       = hash_out;
               res_short_in = 1'b1;
            end else if (hash_out < min_ff) begin
               min_in = hash_out;
            end
         end
         shm_pkg::ST_FINISH: begin
            cont_in = shm_pkg::CONT_FINISH;
            n_in    = 4'(count_ff);
            if (count_ff >= wsize) begin
               res_in       = min_ff;
               res_short_in = 1'b0;
            end
         end
         shm_pkg::ST_EMIT: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_hash_in  = res_ff;
               rsp_short_in = res_short_ff;
               win_in       = '0;
               count_in     = '0;
               min_in       = shm_pkg::HASH_INIT;
               pending_in   = 1'b0;
            end
         end
         default: begin
            step_in = 2'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= shm_pkg::ST_IDLE;
         win_ff       <= '0;
         count_ff     <= '0;
         min_ff       <= shm_pkg::HASH_INIT;
         pending_ff   <= 1'b0;
         skipping_ff  <= 1'b0;
         shingle_ff   <= shm_pkg::SHINGLE_RESET;
         step_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         win_ff       <= win_in;
         count_ff     <= count_in;
         min_ff       <= min_in;
         pending_ff   <= pending_in;
         skipping_ff  <= skipping_in;
         shingle_ff   <= shingle_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cont_ff      <= cont_in;
      byte_ff      <= byte_in;
      last_ff      <= last_in;
      n_ff         <= n_in;
      acc_ff       <= acc_in;
      prod_ff      <= prod_in;
      sum_ff       <= sum_in;
      res_ff       <= res_in;
      res_short_ff <= res_short_in;
      rsp_hash_ff  <= rsp_hash_in;
      rsp_short_ff <= rsp_short_in;
   end

   assign req_ready        = (state_ff == shm_pkg::ST_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cluster_hash = rsp_hash_ff;
   assign rsp_short_string = rsp_short_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= MS)
      else $error("string count beyond window depth");

   a_cr_not_skipping: assert property (@(posedge clock) disable iff (reset)
      !(pending_ff && skipping_ff))
      else $error("held carriage return while skipping");

   a_step_idle: assert property (@(posedge clock) disable iff (reset)
      (step_ff != 2'd0) |-> (state_ff == shm_pkg::ST_MUL1 || state_ff == shm_pkg::ST_MUL2))
      else $error("multiplier step outside multiply states");

   a_rsp_drop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> !rsp_valid)
      else $error("result reloaded in the cycle after a transaction");
`endif

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the shingle min-hash block.
`timescale 1ns / 1ps
module testbench;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [7:0]  req_data_byte = '0;
   logic        req_end_of_buffer = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [63:0] rsp_cluster_hash;
   logic        rsp_short_string;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [3:0]  csr_shingle_size = '0;

   shingle_minhash DUT (.*);

   typedef struct packed {
      logic [63:0] cluster_hash;
      logic        short_string;
   } line_hash_type;

   localparam longint unsigned CYCLE_LIMIT = 2000000;
   localparam int DRAIN_CYCLES = 60;

   // predictor state
   logic [3:0]  size_reg;
   logic [7:0]  win [shm_pkg::MAX_SHINGLE];
   int          count;
   logic [63:0] min_h;
   logic        held_cr;
   logic        skip_rest;

   line_hash_type line_hashes_due [$];
   int          errors = 0;
   int          bytes_sent = 0;
   int          lines_checked = 0;
   longint unsigned cycles = 0;
   int          stall_hold = 0;   // cycles left of a forced receiver hold-off

   initial forever #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("shingle_minhash regression: fail");
         $finish;
      end
   end

   function automatic logic [63:0] mix_final(logic [63:0] h);
      h = h ^ (h >> 33);
      h = h * shm_pkg::P64_2;
      h = h ^ (h >> 29);
      h = h * shm_pkg::P64_3;
      return h ^ (h >> 32);
   endfunction

   function automatic logic [63:0] rotl(logic [63:0] x, int r);
      return (x << r) | (x >> (64 - r));
   endfunction

   // XXH3-64 of 0..8 bytes; bytes are the last n entries of the window
   function automatic logic [63:0] xxh3_short(int n);
      logic [7:0]  p [8];
      logic [63:0] comb, v, h, lo4, hi4;
      for (int i = 0; i < 8; i++)
         p[i] = (i < n) ? win[shm_pkg::MAX_SHINGLE - n + i] : 8'h00;
      if (n == 0) return mix_final(64'h4c263a81e69035e0 ^ 64'hcb00c391bb52283c);
      if (n < 4) begin
         comb = ({56'h0, p[0]} << 16) | ({56'h0, p[n >> 1]} << 24) | {56'h0, p[n - 1]}
                | (64'(n) << 8);
         return mix_final(comb ^ (64'h39_6c_fe_b8 ^ 64'hbe_4b_a4_23));
      end
      lo4 = {32'h0, p[n - 1], p[n - 2], p[n - 3], p[n - 4]};
      hi4 = {32'h0, p[3], p[2], p[1], p[0]};
      v = lo4 + (hi4 << 32);
      h = v ^ (64'h1cad21f72c81017c ^ 64'hdb979083e96dd4de);
      h = h ^ rotl(h, 49) ^ rotl(h, 24);
      h = h * shm_pkg::RRMX_MUL;
      h = h ^ ((h >> 35) + 64'(n));
      h = h * shm_pkg::RRMX_MUL;
      return h ^ (h >> 28);
   endfunction

   function automatic int window_len();
      if (size_reg < 1) return 1;
      if (size_reg > shm_pkg::MAX_SHINGLE) return shm_pkg::MAX_SHINGLE;
      return size_reg;
   endfunction

   function automatic void take_byte(logic [7:0] b);
      logic [63:0] h;
      for (int i = 0; i < shm_pkg::MAX_SHINGLE - 1; i++) win[i] = win[i + 1];
      win[shm_pkg::MAX_SHINGLE - 1] = b;
      if (count < shm_pkg::MAX_SHINGLE) count++;
      if (count >= window_len()) begin
         h = xxh3_short(window_len());
         if (h < min_h) min_h = h;
      end
   endfunction

   function automatic void clear_line();
      for (int i = 0; i < shm_pkg::MAX_SHINGLE; i++) win[i] = '0;
      count = 0;
      min_h = shm_pkg::HASH_INIT;
      held_cr = 0;
   endfunction

   function automatic void close_line();
      line_hash_type r;
      if (count < window_len()) begin
         r.cluster_hash = xxh3_short(count);
         r.short_string = 1;
      end else begin
         r.cluster_hash = min_h;
         r.short_string = 0;
      end
      line_hashes_due.push_back(r);
      clear_line();
   endfunction

   function automatic void predict_byte(logic [7:0] b, logic last);
      if (skip_rest) begin
         if (last) skip_rest = 0;
         return;
      end
      if (held_cr) begin
         held_cr = 0;
         if (b != shm_pkg::LINE_FEED) take_byte(shm_pkg::CARRIAGE_RET);
      end
      if (b == shm_pkg::LINE_FEED) begin
         skip_rest = !last;
         close_line();
         return;
      end
      if (b == shm_pkg::CARRIAGE_RET && !last) begin
         held_cr = 1;
         return;
      end
      take_byte(b);
      if (last) close_line();
   endfunction

   // response side: random stalls, plus a long forced hold-off
   always @(negedge clock) begin
      if (stall_hold > 0) begin
         stall_hold <= stall_hold - 1;
         rsp_ready <= 0;
      end else if ($urandom_range(0, 3) == 0) rsp_ready <= ($urandom_range(0, 9) == 0) ? 0 : 1;
      else rsp_ready <= ($urandom_range(0, 4) != 0);
   end

   always @(posedge clock) begin
      line_hash_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (line_hashes_due.size() == 0) begin
            $error("unexpected result hash=%h short=%b", rsp_cluster_hash, rsp_short_string);
            errors++;
         end else begin
            e = line_hashes_due.pop_front();
            lines_checked++;
            if (rsp_cluster_hash !== e.cluster_hash) begin
               $error("cluster_hash expected %h actual %h", e.cluster_hash, rsp_cluster_hash);
               errors++;
            end
            if (rsp_short_string !== e.short_string) begin
               $error("short_string expected %b actual %b", e.short_string, rsp_short_string);
               errors++;
            end
         end
      end
   end

   task automatic random_gap();
      int g;
      g = $urandom_range(0, 9);
      if (g < 6) g = 0;
      else if (g < 9) g = $urandom_range(1, 3);
      else g = $urandom_range(10, 40);
      if (g > 0) req_valid <= 0;
      repeat (g) @(negedge clock);
   endtask

   // valid stays high into the next transaction when no gap follows
   task automatic send_byte(logic [7:0] b, logic last, bit gaps = 1);
      if (gaps) random_gap();
      req_valid <= 1;
      req_data_byte <= b;
      req_end_of_buffer <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_byte(b, last);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 0;
      while (line_hashes_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_shingle_size(logic [3:0] s);
      wait_drained();
      csr_valid <= 1;
      csr_shingle_size <= s;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      size_reg = s;
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic send_text(string s, logic close = 1);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i], close && (i == s.len() - 1));
   endtask

   task automatic test_directed();
      send_byte(shm_pkg::LINE_FEED, 1);                    // empty line
      send_byte(shm_pkg::CARRIAGE_RET, 0);
      send_byte(shm_pkg::LINE_FEED, 1);                    // CR then LF: still empty
      send_text("ab\n", 0); send_text("xyz", 1);          // tail after LF ignored
      send_byte(8'hFF, 0); send_byte(8'h00, 1);            // extreme bytes, short line
      send_text("a\rb\r", 1);                              // held CR enters, CR ends buffer
      send_text("hello world\r\n", 1);
   endtask

   task automatic test_sizes();
      logic [3:0] sizes [6] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd4, 4'd6};
      foreach (sizes[k]) begin
         write_shingle_size(sizes[k]);
         send_text("abcdefghij\n", 1);
         send_text("abc", 1);
      end
   endtask

   // Well-formed lines with random content; some noise and oversized tails.
   task automatic send_random_line();
      int len;
      logic [7:0] b;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(0, 10);
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(0, 9))
            0: b = shm_pkg::CARRIAGE_RET;
            1: b = 8'($urandom_range(0, 255));
            default: b = 8'($urandom_range(8'h20, 8'h7E));
         endcase
         if (b == shm_pkg::LINE_FEED) b = 8'h41;
         send_byte(b, 0);
      end
      case ($urandom_range(0, 5))
         0: send_byte(8'($urandom_range(0, 255)), 1);
         1: begin
            send_byte(shm_pkg::LINE_FEED, 0);
            repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)), 0);
            send_byte(8'($urandom_range(0, 255)), 1);
         end
         2: begin
            send_byte(shm_pkg::CARRIAGE_RET, 0);
            send_byte(shm_pkg::LINE_FEED, 1);
         end
         default: send_byte(shm_pkg::LINE_FEED, 1);
      endcase
   endtask

   task automatic test_random();
      for (int ph = 0; ph < 8; ph++) begin
         write_shingle_size(4'($urandom_range(0, 15)));
         while (bytes_sent < 80 * (ph + 1) + 90) send_random_line();
      end
   endtask

   task automatic test_backpressure();
      write_shingle_size(4'd2);
      @(negedge clock);
      stall_hold = 400;
      for (int i = 0; i < 12; i++) begin
         send_text("ab\n", 1);
         send_byte(shm_pkg::LINE_FEED, 1, 0);
      end
      // sender pauses until every line hash is back
      wait_drained();
      for (int i = 0; i < 20; i++) send_byte(8'($urandom_range(0, 255)), i == 19, 0);
   endtask

   initial begin
      size_reg = shm_pkg::SHINGLE_RESET;
      skip_rest = 0;
      clear_line();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      test_directed();
      test_sizes();
      test_random();
      test_backpressure();
      wait_drained();
      $display("Sent %0d bytes over sizes 0..15, checked %0d line hashes.",
               bytes_sent, lines_checked);
      if (errors == 0 && line_hashes_due.size() == 0)
         $display("shingle_minhash regression: pass");
      else
         $display("shingle_minhash regression: fail");
      $finish;
   end
endmodule
